/* src/dmx_pkg.sv */
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types and constants for the DMX512 frame bit packer.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int WORD_W     = 32;
    localparam int OFFSET_W   = 16;
    localparam int INDEX_W    = 11;
    localparam int BREAK_W    = 7;
    localparam int MAB_W      = 6;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_WORDS  = 3;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 16'hFFFF;
    localparam logic [BREAK_W-1:0]  BREAK_LIMIT = 7'd64;
    localparam logic [MAB_W-1:0]    MAB_LIMIT   = 6'd32;

    localparam logic [BREAK_W-1:0]  BREAK_RESET  = 7'd24;
    localparam logic [MAB_W-1:0]    MAB_RESET    = 6'd3;
    localparam logic [OFFSET_W-1:0] TARGET_RESET = 16'd7280;

    // register indexes on the config port
    localparam logic [1:0] CFG_BREAK_CELLS = 2'd0;
    localparam logic [1:0] CFG_MAB_CELLS   = 2'd1;
    localparam logic [1:0] CFG_PAD_TARGET  = 2'd2;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_SLOT  = 2'd1,
        REQ_PAD   = 2'd2
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [INDEX_W-1:0]  index;
        logic                done;
        logic [OFFSET_W-1:0] total;
    } res_t;

endpackage

/* src/dmx512_frame_bit_packer.sv */
// ----------------------------------------------------------------------------
// dmx512_frame_bit_packer
// Packs DMX512 break, mark-after-break, slot and pad bit cells into 32-bit
// words, earliest bit in bit 31, and streams out each completed word.
// ----------------------------------------------------------------------------
// A word appears on the master side in the cycle after the request that
// completes it. One request per cycle is taken while each request completes
// at most one word and the master side is not stalled; a start request
// completing two or three words holds off the slave side while the 3-entry
// result queue drains. Reset clears bit offset, word and queue, and loads the
// default break, mark-after-break and pad target values.
// ----------------------------------------------------------------------------
module dmx512_frame_bit_packer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] slot_byte
    input  logic [1:0]  s_tuser,    // [1:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] out_word, [42:32] word_index,
                                    // [58:43] total_bits, [63:59] zero
    output logic        m_tlast     // frame_done
);

    // configuration
    logic [dmx_pkg::BREAK_W-1:0]  break_reg;
    logic [dmx_pkg::MAB_W-1:0]    mab_reg;
    logic [dmx_pkg::OFFSET_W-1:0] target_reg;

    // frame state
    logic [dmx_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [dmx_pkg::WORD_W-1:0]   acc_reg, acc_next;

    // result queue
    dmx_pkg::res_t q_reg [dmx_pkg::MAX_WORDS];
    logic [1:0]    rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;

    dmx_pkg::res_t res_new [dmx_pkg::MAX_WORDS];
    logic [1:0]    n_new;
    dmx_pkg::res_t head;

    logic accept;
    logic pop;

    // slot path
    logic [4:0]  pos;
    logic [15:0] avail;
    logic [3:0]  k_slot;
    logic [10:0] slot_bits;
    logic [10:0] slot_keep;
    logic [63:0] win;
    logic [5:0]  pos_sum;

    // pad path
    logic        pad_go;
    logic        pad_sat;
    logic [31:0] fill;
    logic [31:0] pad_word;
    logic [15:0] pad_total;

    // start path
    logic [6:0]  nb;
    logic [5:0]  nm;
    logic [6:0]  tot_cells;
    logic [95:0] seq;

    assign pop      = m_tvalid && m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    assign head     = q_reg[rd_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {5'd0, head.total, head.index, head.word};
    assign m_tlast  = head.done;

    // ---------------------------------------------------------------- slot
    always_comb
    begin
        pos   = off_reg[4:0];
        avail = dmx_pkg::OFFSET_MAX - off_reg;
        if (avail >= 16'd11)
            k_slot = 4'd11;
        else
            k_slot = avail[3:0];

        // start bit, data LSB first, two stop bits; first bit at the MSB
        slot_bits[10] = 1'b0;
        for (int i = 0; i < 8; i++)
            slot_bits[9-i] = s_tdata[i];
        slot_bits[1:0] = 2'b11;

        // near saturation only the leading k bits are kept
        slot_keep = slot_bits & ~(11'h7FF >> k_slot);
        win       = {acc_reg, 32'h0} | ({53'h0, slot_keep} << (6'd53 - {1'b0, pos}));
        pos_sum   = {1'b0, pos} + {2'b0, k_slot};
    end

    // ----------------------------------------------------------------- pad
    always_comb
    begin
        pad_go  = (off_reg != dmx_pkg::OFFSET_MAX) &&
                  !((pos == 5'd0) && (off_reg >= target_reg));
        pad_sat = (off_reg[15:5] == 11'h7FF);
        fill    = 32'hFFFF_FFFF >> pos;
        if (pad_sat)
            fill = fill & ~32'h1;       // last cell position is never stored
        pad_word  = acc_reg | fill;
        pad_total = {off_reg[15:5] + 11'd1, 5'd0};
    end

    // --------------------------------------------------------------- start
    always_comb
    begin
        nb        = (break_reg > dmx_pkg::BREAK_LIMIT) ? dmx_pkg::BREAK_LIMIT : break_reg;
        nm        = (mab_reg > dmx_pkg::MAB_LIMIT) ? dmx_pkg::MAB_LIMIT : mab_reg;
        tot_cells = nb + {1'b0, nm};
        seq       = ({96{1'b1}} >> nb) & ~({96{1'b1}} >> tot_cells);
    end

    // ------------------------------------------------------ request decode
    always_comb
    begin
        off_next = off_reg;
        acc_next = acc_reg;
        n_new    = 2'd0;
        for (int k = 0; k < dmx_pkg::MAX_WORDS; k++)
        begin
            res_new[k].word  = seq[95-32*k -: 32];
            res_new[k].index = 11'(k);
            res_new[k].done  = 1'b0;
            res_new[k].total = 16'(32 * (k + 1));
        end

        unique case (dmx_pkg::req_t'(s_tuser))
            dmx_pkg::REQ_START:
            begin
                off_next = {9'd0, tot_cells};
                n_new    = tot_cells[6:5];
                case (tot_cells[6:5])
                    2'd0:    acc_next = seq[95:64];
                    2'd1:    acc_next = seq[63:32];
                    2'd2:    acc_next = seq[31:0];
                    default: acc_next = 32'h0;
                endcase
            end
            dmx_pkg::REQ_SLOT:
            begin
                off_next = off_reg + {12'd0, k_slot};
                if (pos_sum[5])
                begin
                    acc_next         = win[31:0];
                    n_new            = 2'd1;
                    res_new[0].word  = win[63:32];
                    res_new[0].index = off_reg[15:5];
                    res_new[0].total = pad_total;
                end
                else
                begin
                    acc_next = win[63:32];
                end
            end
            dmx_pkg::REQ_PAD:
            begin
                if (pad_go)
                begin
                    if (pad_sat)
                    begin
                        acc_next = pad_word;
                        off_next = dmx_pkg::OFFSET_MAX;
                    end
                    else
                    begin
                        acc_next         = 32'h0;
                        off_next         = pad_total;
                        n_new            = 2'd1;
                        res_new[0].word  = pad_word;
                        res_new[0].index = off_reg[15:5];
                        res_new[0].done  = (pad_total >= target_reg);
                        res_new[0].total = pad_total;
                    end
                end
            end
            default:
            begin
                off_next = off_reg;
            end
        endcase
    end

    // ---------------------------------------------------------- queue ctrl
    always_comb
    begin
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            rd_next  = 2'd0;
            cnt_next = n_new;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = (cnt_reg == 2'd1) ? 2'd0 : rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_reg  <= dmx_pkg::BREAK_RESET;
            mab_reg    <= dmx_pkg::MAB_RESET;
            target_reg <= dmx_pkg::TARGET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dmx_pkg::CFG_BREAK_CELLS: break_reg  <= cfg_wdata[dmx_pkg::BREAK_W-1:0];
                dmx_pkg::CFG_MAB_CELLS:   mab_reg    <= cfg_wdata[dmx_pkg::MAB_W-1:0];
                dmx_pkg::CFG_PAD_TARGET:  target_reg <= cfg_wdata;
                default:                  target_reg <= target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            acc_reg <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                off_reg <= off_next;
                acc_reg <= acc_next;
            end
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < dmx_pkg::MAX_WORDS; k++)
                q_reg[k] <= res_new[k];
        end
    end

    // ---------------------------------------------------------- assertions
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rd_reg} + {1'b0, cnt_reg}) <= 3'd3)
        else $error("result queue read past its last entry");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg >= 2'd2) |-> !s_tready)
        else $error("request taken while several words still queued");

    a_aligned_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (off_reg[4:0] == 5'd0) |-> (acc_reg == 32'h0))
        else $error("partial word not empty at a word boundary");

    a_total_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[58:43] == {m_tdata[42:32] + 11'd1, 5'd0}))
        else $error("total_bits does not follow word_index");

endmodule
